FILE: rtl/urb_pkg.sv
`timescale 1ns / 1ps

package urb_pkg;

  localparam int DATA_W = 8;
  localparam int LIMIT_W = 16;
  localparam int LEVEL_W = 7;
  localparam int RX_DEPTH_DEF = 64;
  localparam int TX_DEPTH_DEF = 64;

  typedef enum logic [2:0] {
    OP_RX_BYTE    = 3'd0,
    OP_HOST_READ  = 3'd1,
    OP_HOST_WRITE = 3'd2,
    OP_TX_EMPTY   = 3'd3,
    OP_FLUSH_RX   = 3'd4,
    OP_FLUSH_TX   = 3'd5,
    OP_SET_ENABLE = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_HOST = 2'd1,
    KIND_LINE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_TX
  } state_t;

endpackage

FILE: rtl/uart_rx_tx_ring_buffers.sv
`timescale 1ns / 1ps

// Buffered UART interface: a receive ring store and a transmit ring queue
// between a serial line and a host, both held in synchronous memories.
// Input channel (in_valid/in_ready) carries one event per request: received
// line byte, host read, host write, transmitter empty, flushes, enable.
// Output channel (out_valid/out_ready) returns the results; last marks the
// final result of each request.
// Timing: events that need no memory read, and an empty host read, answer
// in the cycle after the request. A transmitter-empty event with queued
// data reads the transmit memory, then answers from the S_TX state. A host
// read of n bytes enters S_READ, issues receive memory reads and then
// returns one byte per cycle while the receiver does not stall.
// Throughput: one request per cycle for most events while the output is
// not stalled, one request in flight at a time; a transmitter-empty event
// with queued data holds the input during S_TX, a read until its last byte.
// Reset clears pointers, levels, flags and out_valid; memory
// contents are left as they are and are only read after being written.
// On a receiver stall the output register holds its result and the block stops
// accepting requests and, with a read byte held, memory reads until it drains.

module uart_rx_tx_ring_buffers #(
  parameter int RX_DEPTH = urb_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = urb_pkg::TX_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    opcode,
  input  logic [urb_pkg::DATA_W-1:0]    data_in,
  input  logic [urb_pkg::LIMIT_W-1:0]   read_limit,
  input  logic                          enable_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    kind,
  output logic [urb_pkg::DATA_W-1:0]    data_out,
  output logic                          last,
  output logic [urb_pkg::LEVEL_W-1:0]   delivered_count,
  output logic [urb_pkg::LEVEL_W-1:0]   rx_level,
  output logic [urb_pkg::LEVEL_W-1:0]   tx_level,
  output logic                          overflow_seen,
  output logic                          receive_on,
  output logic                          write_rejected
);

  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int LW = urb_pkg::LEVEL_W;
  localparam int DW = urb_pkg::DATA_W;

  urb_pkg::state_t state, state_next;

  logic [RX_AW-1:0] rx_wptr, rx_wptr_next, rx_rptr, rx_rptr_next;
  logic [TX_AW-1:0] tx_wptr, tx_wptr_next, tx_rptr, tx_rptr_next;
  logic [LW-1:0]    rx_fill, rx_fill_next, tx_fill, tx_fill_next;
  logic [LW-1:0]    rx_fill_inc;
  logic             ovf, ovf_next, rx_en, rx_en_next, busy, busy_next;
  logic [LW-1:0]    read_count, read_count_next;
  logic [LW-1:0]    issue_left, issue_left_next, deliver_left, deliver_left_next;
  logic [LW-1:0]    take_n;
  logic             q_valid, q_valid_next;

  logic             rx_we, rx_re, tx_we, tx_re;
  logic [DW-1:0]    rx_q, tx_q;

  logic             slot_free, load;
  urb_pkg::kind_t   load_kind;
  logic [DW-1:0]    load_data;
  logic             load_last, load_rej;
  logic [LW-1:0]    load_count;

  urb_ram #(.DEPTH(RX_DEPTH), .AW(RX_AW)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_wptr),
    .wdata (data_in),
    .re    (rx_re),
    .raddr (rx_rptr),
    .rdata (rx_q)
  );

  urb_ram #(.DEPTH(TX_DEPTH), .AW(TX_AW)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_wptr),
    .wdata (data_in),
    .re    (tx_re),
    .raddr (tx_rptr),
    .rdata (tx_q)
  );

  assign slot_free = !out_valid || out_ready;
  assign rx_fill_inc = rx_fill + LW'(1);
  assign take_n = (read_limit < LW'(0) + urb_pkg::LIMIT_W'(rx_fill)) ?
                  read_limit[LW-1:0] : rx_fill;

  always_comb begin
    state_next        = state;
    rx_wptr_next      = rx_wptr;
    rx_rptr_next      = rx_rptr;
    tx_wptr_next      = tx_wptr;
    tx_rptr_next      = tx_rptr;
    rx_fill_next      = rx_fill;
    tx_fill_next      = tx_fill;
    ovf_next          = ovf;
    rx_en_next        = rx_en;
    busy_next         = busy;
    read_count_next   = read_count;
    issue_left_next   = issue_left;
    deliver_left_next = deliver_left;
    rx_we             = 1'b0;
    rx_re             = 1'b0;
    tx_we             = 1'b0;
    tx_re             = 1'b0;
    in_ready          = 1'b0;
    load              = 1'b0;
    load_kind         = urb_pkg::KIND_ACK;
    load_data         = '0;
    load_last         = 1'b1;
    load_count        = '0;
    load_rej          = 1'b0;
    case (state)
      urb_pkg::S_IDLE: begin
        in_ready = slot_free;
        if (in_valid && slot_free) begin
          case (opcode)
            urb_pkg::OP_RX_BYTE: begin
              load = 1'b1;
              if (rx_en) begin
                rx_we = 1'b1;
                rx_wptr_next = (rx_wptr == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_wptr + RX_AW'(1);
                if (rx_fill_inc >= LW'(RX_DEPTH)) begin
                  rx_fill_next = LW'(RX_DEPTH);
                  rx_en_next = 1'b0;
                  ovf_next = 1'b1;
                end else begin
                  rx_fill_next = rx_fill_inc;
                end
              end
            end
            urb_pkg::OP_HOST_READ: begin
              if (take_n == '0) begin
                load = 1'b1;
              end else begin
                rx_fill_next = rx_fill - take_n;
                read_count_next = take_n;
                issue_left_next = take_n;
                deliver_left_next = take_n;
                state_next = urb_pkg::S_READ;
              end
            end
            urb_pkg::OP_HOST_WRITE: begin
              load = 1'b1;
              if (tx_fill == '0 && !busy) begin
                busy_next = 1'b1;
                load_kind = urb_pkg::KIND_LINE;
                load_data = data_in;
              end else if (tx_fill >= LW'(TX_DEPTH)) begin
                load_rej = 1'b1;
              end else begin
                tx_we = 1'b1;
                tx_wptr_next = (tx_wptr == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_wptr + TX_AW'(1);
                tx_fill_next = tx_fill + LW'(1);
              end
            end
            urb_pkg::OP_TX_EMPTY: begin
              if (tx_fill != '0) begin
                tx_re = 1'b1;
                tx_rptr_next = (tx_rptr == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_rptr + TX_AW'(1);
                tx_fill_next = tx_fill - LW'(1);
                busy_next = 1'b1;
                state_next = urb_pkg::S_TX;
              end else begin
                busy_next = 1'b0;
                load = 1'b1;
              end
            end
            urb_pkg::OP_FLUSH_RX: begin
              load = 1'b1;
              rx_wptr_next = '0;
              rx_rptr_next = '0;
              rx_fill_next = '0;
              ovf_next = 1'b0;
            end
            urb_pkg::OP_FLUSH_TX: begin
              load = 1'b1;
              tx_wptr_next = '0;
              tx_rptr_next = '0;
              tx_fill_next = '0;
            end
            urb_pkg::OP_SET_ENABLE: begin
              load = 1'b1;
              rx_en_next = enable_value;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      urb_pkg::S_READ: begin
        load = q_valid && slot_free;
        rx_re = (issue_left != '0) && (!q_valid || load);
        if (rx_re) begin
          rx_rptr_next = (rx_rptr == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_rptr + RX_AW'(1);
          issue_left_next = issue_left - LW'(1);
        end
        if (load) begin
          load_kind = urb_pkg::KIND_HOST;
          load_data = rx_q;
          load_count = read_count;
          load_last = (deliver_left == LW'(1));
          deliver_left_next = deliver_left - LW'(1);
          if (deliver_left == LW'(1)) begin
            state_next = urb_pkg::S_IDLE;
          end
        end
      end
      urb_pkg::S_TX: begin
        load = slot_free;
        load_kind = urb_pkg::KIND_LINE;
        load_data = tx_q;
        if (slot_free) begin
          state_next = urb_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = urb_pkg::S_IDLE;
      end
    endcase
    q_valid_next = rx_re || (q_valid && !load);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= urb_pkg::S_IDLE;
      rx_wptr      <= '0;
      rx_rptr      <= '0;
      tx_wptr      <= '0;
      tx_rptr      <= '0;
      rx_fill      <= '0;
      tx_fill      <= '0;
      ovf          <= 1'b0;
      rx_en        <= 1'b0;
      busy         <= 1'b0;
      read_count   <= '0;
      issue_left   <= '0;
      deliver_left <= '0;
      q_valid      <= 1'b0;
    end else begin
      state        <= state_next;
      rx_wptr      <= rx_wptr_next;
      rx_rptr      <= rx_rptr_next;
      tx_wptr      <= tx_wptr_next;
      tx_rptr      <= tx_rptr_next;
      rx_fill      <= rx_fill_next;
      tx_fill      <= tx_fill_next;
      ovf          <= ovf_next;
      rx_en        <= rx_en_next;
      busy         <= busy_next;
      read_count   <= read_count_next;
      issue_left   <= issue_left_next;
      deliver_left <= deliver_left_next;
      q_valid      <= q_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind            <= load_kind;
      data_out        <= load_data;
      last            <= load_last;
      delivered_count <= load_count;
      rx_level        <= rx_fill_next;
      tx_level        <= tx_fill_next;
      overflow_seen   <= ovf_next;
      receive_on      <= rx_en_next;
      write_rejected  <= load_rej;
    end
  end

endmodule

FILE: rtl/urb_ram.sv
`timescale 1ns / 1ps

module urb_ram #(
  parameter int DEPTH = urb_pkg::RX_DEPTH_DEF,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [urb_pkg::DATA_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [urb_pkg::DATA_W-1:0] rdata
);

  logic [urb_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: test/uart_buffers_check.sv
`timescale 1ns / 1ps

module uart_buffers_check
  import urb_pkg::*;
#(
  parameter int RX_DEPTH = RX_DEPTH_DEF,
  parameter int TX_DEPTH = TX_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         opcode,
  input  logic [DATA_W-1:0]  data_in,
  input  logic [LIMIT_W-1:0] read_limit,
  input  logic               enable_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         kind,
  input  logic [DATA_W-1:0]  data_out,
  input  logic               last,
  input  logic [LEVEL_W-1:0] delivered_count,
  input  logic [LEVEL_W-1:0] rx_level,
  input  logic [LEVEL_W-1:0] tx_level,
  input  logic               overflow_seen,
  input  logic               receive_on,
  input  logic               write_rejected,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    kind_t              kind;
    logic [DATA_W-1:0]  data;
    logic               last;
    logic [LEVEL_W-1:0] count;
    logic [LEVEL_W-1:0] rx_lvl;
    logic [LEVEL_W-1:0] tx_lvl;
    logic               ovf;
    logic               ren;
    logic               rej;
  } buf_result_t;

  logic [DATA_W-1:0] rx_mem [RX_DEPTH];
  logic [DATA_W-1:0] tx_mem [TX_DEPTH];
  int rx_wr, rx_rd, rx_cnt;
  int tx_wr, tx_rd, tx_cnt;
  bit ovf_flag, rx_en, tx_busy;
  buf_result_t due_results [$];

  function automatic int wrap_inc(int pos, int depth);
    return (pos + 1 >= depth) ? 0 : pos + 1;
  endfunction

  task automatic push_result(kind_t k, logic [DATA_W-1:0] d, logic l, int n, logic rej);
    buf_result_t r;
    r.kind   = k;
    r.data   = d;
    r.last   = l;
    r.count  = LEVEL_W'(n);
    r.rx_lvl = LEVEL_W'(rx_cnt);
    r.tx_lvl = LEVEL_W'(tx_cnt);
    r.ovf    = ovf_flag;
    r.ren    = rx_en;
    r.rej    = rej;
    due_results.push_back(r);
  endtask

  task automatic step_buffers(logic [2:0] op, logic [DATA_W-1:0] d, logic [LIMIT_W-1:0] lim,
                              logic en);
    int n;
    int i;
    logic [DATA_W-1:0] taken [RX_DEPTH];
    case (op)
      OP_RX_BYTE: begin
        if (rx_en) begin
          rx_mem[rx_wr] = d;
          rx_wr = wrap_inc(rx_wr, RX_DEPTH);
          rx_cnt++;
          if (rx_cnt >= RX_DEPTH) begin
            rx_cnt = RX_DEPTH;
            rx_en = 1'b0;
            ovf_flag = 1'b1;
          end
        end
        push_result(KIND_ACK, '0, 1'b1, 0, 1'b0);
      end
      OP_HOST_READ: begin
        n = (rx_cnt < int'(lim)) ? rx_cnt : int'(lim);
        if (n > RX_DEPTH) n = RX_DEPTH;
        if (n == 0) begin
          push_result(KIND_ACK, '0, 1'b1, 0, 1'b0);
        end else begin
          for (i = 0; i < n; i++) begin
            taken[i] = rx_mem[rx_rd];
            rx_rd = wrap_inc(rx_rd, RX_DEPTH);
          end
          rx_cnt -= n;
          for (i = 0; i < n; i++) push_result(KIND_HOST, taken[i], i + 1 == n, n, 1'b0);
        end
      end
      OP_HOST_WRITE: begin
        if (tx_cnt == 0 && !tx_busy) begin
          tx_busy = 1'b1;
          push_result(KIND_LINE, d, 1'b1, 0, 1'b0);
        end else if (tx_cnt >= TX_DEPTH) begin
          push_result(KIND_ACK, '0, 1'b1, 0, 1'b1);
        end else begin
          tx_mem[tx_wr] = d;
          tx_wr = wrap_inc(tx_wr, TX_DEPTH);
          tx_cnt++;
          push_result(KIND_ACK, '0, 1'b1, 0, 1'b0);
        end
      end
      OP_TX_EMPTY: begin
        if (tx_cnt > 0) begin
          n = tx_rd;
          tx_rd = wrap_inc(tx_rd, TX_DEPTH);
          tx_cnt--;
          tx_busy = 1'b1;
          push_result(KIND_LINE, tx_mem[n], 1'b1, 0, 1'b0);
        end else begin
          tx_busy = 1'b0;
          push_result(KIND_ACK, '0, 1'b1, 0, 1'b0);
        end
      end
      OP_FLUSH_RX: begin
        rx_wr = 0;
        rx_rd = 0;
        rx_cnt = 0;
        ovf_flag = 1'b0;
        push_result(KIND_ACK, '0, 1'b1, 0, 1'b0);
      end
      OP_FLUSH_TX: begin
        tx_wr = 0;
        tx_rd = 0;
        tx_cnt = 0;
        push_result(KIND_ACK, '0, 1'b1, 0, 1'b0);
      end
      OP_SET_ENABLE: begin
        rx_en = en;
        push_result(KIND_ACK, '0, 1'b1, 0, 1'b0);
      end
      default: begin
        push_result(KIND_ACK, '0, 1'b1, 0, 1'b0);
      end
    endcase
  endtask

  task automatic check_field(string name, logic [15:0] exp, logic [15:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp, act);
      errors++;
    end
  endtask

  task automatic check_result();
    buf_result_t r;
    if (due_results.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual kind %0h data %0h",
               $time, kind, data_out);
      errors++;
    end else begin
      r = due_results.pop_front();
      check_field("kind", 16'(r.kind), 16'(kind));
      check_field("data_out", 16'(r.data), 16'(data_out));
      check_field("last", 16'(r.last), 16'(last));
      check_field("delivered_count", 16'(r.count), 16'(delivered_count));
      check_field("rx_level", 16'(r.rx_lvl), 16'(rx_level));
      check_field("tx_level", 16'(r.tx_lvl), 16'(tx_level));
      check_field("overflow_seen", 16'(r.ovf), 16'(overflow_seen));
      check_field("receive_on", 16'(r.ren), 16'(receive_on));
      check_field("write_rejected", 16'(r.rej), 16'(write_rejected));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rx_wr = 0;
      rx_rd = 0;
      rx_cnt = 0;
      tx_wr = 0;
      tx_rd = 0;
      tx_cnt = 0;
      ovf_flag = 1'b0;
      rx_en = 1'b0;
      tx_busy = 1'b0;
      due_results.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) step_buffers(opcode, data_in, read_limit, enable_value);
    end
    pending = due_results.size();
  end

endmodule

FILE: test/tb_uart_rx_tx_ring_buffers.sv
`timescale 1ns / 1ps

module tb_uart_rx_tx_ring_buffers;
  import urb_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int RX_DEPTH = RX_DEPTH_DEF;
  localparam int TX_DEPTH = TX_DEPTH_DEF;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 40;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         opcode = OP_RX_BYTE;
  logic [DATA_W-1:0]  data_in = '0;
  logic [LIMIT_W-1:0] read_limit = '0;
  logic               enable_value = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         kind;
  logic [DATA_W-1:0]  data_out;
  logic               last;
  logic [LEVEL_W-1:0] delivered_count;
  logic [LEVEL_W-1:0] rx_level;
  logic [LEVEL_W-1:0] tx_level;
  logic               overflow_seen;
  logic               receive_on;
  logic               write_rejected;
  int                 errors;
  int                 pending;

  bit bursty = 1'b0;
  bit hold_req = 1'b0;
  int sent = 0;

  always #1 clk = ~clk;

  uart_rx_tx_ring_buffers #(
    .RX_DEPTH(RX_DEPTH),
    .TX_DEPTH(TX_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .data_in(data_in),
    .read_limit(read_limit),
    .enable_value(enable_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .data_out(data_out),
    .last(last),
    .delivered_count(delivered_count),
    .rx_level(rx_level),
    .tx_level(tx_level),
    .overflow_seen(overflow_seen),
    .receive_on(receive_on),
    .write_rejected(write_rejected)
  );

  uart_buffers_check #(
    .RX_DEPTH(RX_DEPTH),
    .TX_DEPTH(TX_DEPTH)
  ) chk (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .data_in(data_in),
    .read_limit(read_limit),
    .enable_value(enable_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .data_out(data_out),
    .last(last),
    .delivered_count(delivered_count),
    .rx_level(rx_level),
    .tx_level(tx_level),
    .overflow_seen(overflow_seen),
    .receive_on(receive_on),
    .write_rejected(write_rejected),
    .errors(errors),
    .pending(pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (bursty) return 0;
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DATA_W-1:0] rand_byte();
    return DATA_W'($urandom);
  endfunction

  function automatic logic [LIMIT_W-1:0] rand_limit();
    return LIMIT_W'($urandom);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom);
  endfunction

  // hold the request until accepted, then idle for a random gap
  task automatic send_req(logic [2:0] op, logic [DATA_W-1:0] d, logic [LIMIT_W-1:0] lim,
                          logic en);
    int gap;
    opcode <= op;
    data_in <= d;
    read_limit <= lim;
    enable_value <= en;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_any(logic [2:0] op);
    send_req(op, rand_byte(), rand_limit(), rand_bit());
  endtask

  task automatic set_rx_enable(logic en);
    send_req(OP_SET_ENABLE, rand_byte(), rand_limit(), en);
  endtask

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin
    int start;
    int n;
    logic [LIMIT_W-1:0] lim;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_rx_enable(1'b1);
    send_req(OP_RX_BYTE, 8'h00, rand_limit(), rand_bit());
    send_req(OP_RX_BYTE, 8'hFF, rand_limit(), rand_bit());
    send_req(OP_RX_BYTE, 8'hA5, rand_limit(), rand_bit());
    send_req(OP_HOST_READ, rand_byte(), 16'h0000, rand_bit());
    send_req(OP_HOST_READ, rand_byte(), 16'hFFFF, rand_bit());
    send_req(OP_HOST_READ, rand_byte(), 16'h0001, rand_bit());
    send_any(OP_TX_EMPTY);
    send_req(OP_HOST_WRITE, 8'h00, rand_limit(), rand_bit());
    send_req(OP_HOST_WRITE, 8'hFF, rand_limit(), rand_bit());
    send_req(OP_HOST_WRITE, 8'h5A, rand_limit(), rand_bit());
    repeat (3) send_any(OP_TX_EMPTY);
    set_rx_enable(1'b0);
    send_req(OP_RX_BYTE, 8'h3C, rand_limit(), rand_bit());
    set_rx_enable(1'b1);
    send_req(OP_RX_BYTE, 8'h81, rand_limit(), rand_bit());
    send_any(OP_FLUSH_RX);
    send_req(OP_HOST_WRITE, 8'h11, rand_limit(), rand_bit());
    send_req(OP_HOST_WRITE, 8'h22, rand_limit(), rand_bit());
    send_any(OP_FLUSH_TX);
    send_req(OP_HOST_WRITE, 8'h33, rand_limit(), rand_bit());
    send_any(OP_UNUSED);
    send_any(OP_TX_EMPTY);
    send_any(OP_TX_EMPTY);

    // fill the receive store past full, re-enable and overwrite
    set_rx_enable(1'b1);
    repeat (RX_DEPTH + 2) send_any(OP_RX_BYTE);
    set_rx_enable(1'b1);
    send_any(OP_RX_BYTE);
    send_any(OP_RX_BYTE);
    send_req(OP_HOST_READ, rand_byte(), 16'hFFFF, rand_bit());
    send_req(OP_HOST_READ, rand_byte(), LIMIT_W'($urandom_range(1, 9)), rand_bit());

    // fill the transmit queue while the receiver holds off
    hold_req = 1'b1;
    repeat (TX_DEPTH + 3) send_any(OP_HOST_WRITE);
    repeat (4) send_any(OP_TX_EMPTY);

    start = sent;
    while (sent - start < RANDOM_ITEMS) begin
      bursty = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          if ($urandom_range(0, 1)) set_rx_enable(1'b1);
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 12);
          repeat (n) send_any(OP_RX_BYTE);
        end
        3, 4: begin
          case ($urandom_range(0, 3))
            0: lim = 16'hFFFF;
            1: lim = rand_limit();
            default: lim = LIMIT_W'($urandom_range(0, 20));
          endcase
          send_req(OP_HOST_READ, rand_byte(), lim, rand_bit());
        end
        5: begin
          repeat ($urandom_range(1, 10)) send_any(OP_HOST_WRITE);
          repeat ($urandom_range(0, 12)) send_any(OP_TX_EMPTY);
        end
        6: repeat ($urandom_range(1, 3)) send_any(OP_TX_EMPTY);
        7: begin
          case ($urandom_range(0, 2))
            0: send_any(OP_FLUSH_RX);
            1: send_any(OP_FLUSH_TX);
            default: send_any(OP_SET_ENABLE);
          endcase
        end
        default: repeat ($urandom_range(1, 5)) send_any(3'($urandom_range(0, 7)));
      endcase
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("** uart_rx_tx_ring_buffers: PASSED **");
    end else begin
      $display("** uart_rx_tx_ring_buffers: FAILED **");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("** uart_rx_tx_ring_buffers: FAILED **");
    $finish;
  end

endmodule
